[src/csfd_pkg.sv]
// Package for the camera select frame decoder.
// Holds frame byte codes, event codes and the frame classifier.
// No dependencies.
`default_nettype none

package csfd_pkg;

   // Frame delimiters and body codes
   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_ETX = 8'h03;
   localparam logic [7:0] BYTE_RST = 8'h40;
   localparam logic [7:0] DIGIT_0  = 8'h30;
   localparam logic [7:0] DIGIT_1  = 8'h31;
   localparam logic [7:0] DIGIT_6  = 8'h36;
   localparam logic [7:0] DIGIT_9  = 8'h39;

   // Width of one camera id and of the mask port
   localparam int unsigned ID_W   = 5;
   localparam int unsigned MASK_W = 16;

   // Event codes on rsp_event_kind
   localparam logic EVT_SELECT = 1'b0;
   localparam logic EVT_RESET  = 1'b1;

   typedef enum logic [1:0] {
      FRM_NONE,
      FRM_CAMERA,
      FRM_RESET
   } frame_kind_type;

   typedef struct packed {
      frame_kind_type kind;
      logic [ID_W-1:0] id;
   } frame_info_type;

   // Classify a four-byte window and decode the camera id
   function automatic frame_info_type classify(input logic [7:0] w0, input logic [7:0] w1,
                                               input logic [7:0] w2, input logic [7:0] w3);
      frame_info_type info;
      info.kind = FRM_NONE;
      info.id   = '0;
      if (w0 == BYTE_STX && w3 == BYTE_ETX) begin
         if (w1 == BYTE_RST && w2 == BYTE_RST) begin
            info.kind = FRM_RESET;
         end else if (w1 == DIGIT_0 && w2 >= DIGIT_1 && w2 <= DIGIT_9) begin
            info.kind = FRM_CAMERA;
            info.id   = {1'b0, w2[3:0]};
         end else if (w1 == DIGIT_1 && w2 >= DIGIT_0 && w2 <= DIGIT_6) begin
            info.kind = FRM_CAMERA;
            info.id   = 5'd10 + {1'b0, w2[3:0]};
         end
      end
      return info;
   endfunction

endpackage

`default_nettype wire

[src/camera_select_frame_decoder.sv]
// Camera select frame decoder, top level.
// Uses csfd_pkg for byte codes, event codes and the frame classifier.
//
// Usage:
//   req_*  : one received serial byte per word (valid/ready).
//   rsp_*  : event words: select or reset, camera id 1..MAX_CAMERAS, and
//            last set on the final event caused by one byte (valid/ready).
//   csr_*  : write of the registered camera mask, always ready; write it only
//            while the block is idle.
// Bytes collect in a window of three pending bytes; the fourth completes a
// frame STX, body, body, ETX. A camera frame gives at most one event, in the
// cycle after the byte is taken. A reset frame starts a scan of the
// active-and-registered set by a shift register, one camera id per cycle
// while no hit waits for the output, up to the highest hit id; the input is
// held until the scan ends. Other bytes start no scan.
// The result sits in an output register; a new byte is taken in the cycle
// that register empties. A receiver stall holds the scan at a hit, and the input.
// Synchronous reset empties the window, clears the active set, the mask and
// the output register.
`default_nettype none

module camera_select_frame_decoder #(
   parameter int unsigned MAX_CAMERAS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   // event output
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_event_kind,
   output logic [4:0]       rsp_camera_id,
   output logic             rsp_last,
   // mask write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_registered_mask
);

   localparam int unsigned MW = csfd_pkg::MASK_W;
   localparam int unsigned IW = csfd_pkg::ID_W;
   localparam logic [MW-1:0] IdMask = MW'((33'd1 << MAX_CAMERAS) - 33'd1);
   localparam logic [IW-1:0] MaxId  = IW'(MAX_CAMERAS);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        pend0_ff, pend0_in;
   logic [7:0]        pend1_ff, pend1_in;
   logic [7:0]        pend2_ff, pend2_in;
   logic [1:0]        count_ff, count_in;
   logic [MW-1:0]     active_ff, active_in;
   logic [MW-1:0]     regmask_ff, regmask_in;
   logic [MW-1:0]     hits_ff, hits_in;
   logic [IW-1:0]     scan_id_ff, scan_id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [IW-1:0]     rsp_id_ff, rsp_id_in;
   logic              rsp_last_ff, rsp_last_in;

   logic                    rsp_free;
   logic                    take;
   csfd_pkg::frame_info_type info;
   logic [IW-1:0]           id_m1;
   logic [MW-1:0]           new_hits;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign take      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign info     = csfd_pkg::classify(pend0_ff, pend1_ff, pend2_ff, req_rx_byte);
   assign id_m1    = info.id - IW'(1);
   assign new_hits = active_ff & regmask_ff & IdMask;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_camera_id  = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;

   // Next-state logic: window update, frame action, reset scan
   always_comb begin
      state_in     = state_ff;
      pend0_in     = pend0_ff;
      pend1_in     = pend1_ff;
      pend2_in     = pend2_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      regmask_in   = regmask_ff;
      hits_in      = hits_ff;
      scan_id_in   = scan_id_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;

      // drop the output word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // take a mask write
      if (csr_valid) begin
         regmask_in = csr_registered_mask;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               priority if (count_ff != 2'd3) begin
                  // append to the window
                  unique case (count_ff)
                     2'd0:    pend0_in = req_rx_byte;
                     2'd1:    pend1_in = req_rx_byte;
                     default: pend2_in = req_rx_byte;
                  endcase
                  count_in = count_ff + 2'd1;
               end else if (info.kind == csfd_pkg::FRM_NONE) begin
                  // drop the first byte and everything up to the next STX
                  priority if (pend1_ff == csfd_pkg::BYTE_STX) begin
                     pend0_in = pend1_ff;
                     pend1_in = pend2_ff;
                     pend2_in = req_rx_byte;
                     count_in = 2'd3;
                  end else if (pend2_ff == csfd_pkg::BYTE_STX) begin
                     pend0_in = pend2_ff;
                     pend1_in = req_rx_byte;
                     count_in = 2'd2;
                  end else if (req_rx_byte == csfd_pkg::BYTE_STX) begin
                     pend0_in = req_rx_byte;
                     count_in = 2'd1;
                  end else begin
                     count_in = 2'd0;
                  end
               end else if (info.kind == csfd_pkg::FRM_CAMERA) begin
                  count_in = 2'd0;
                  if (info.id <= MaxId && regmask_ff[id_m1[IW-2:0]]) begin
                     active_in    = active_ff | (MW'(1) << id_m1[IW-2:0]);
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = csfd_pkg::EVT_SELECT;
                     rsp_id_in    = info.id;
                     rsp_last_in  = 1'b1;
                  end
               end else begin
                  // reset frame: clear the active set, scan what was hit
                  count_in  = 2'd0;
                  active_in = '0;
                  if (new_hits != '0) begin
                     hits_in    = new_hits;
                     scan_id_in = IW'(1);
                     state_in   = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // advance one id per cycle; hold while a hit waits for the output
            if (!hits_ff[0] || rsp_free) begin
               if (hits_ff[0]) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = csfd_pkg::EVT_RESET;
                  rsp_id_in    = scan_id_ff;
                  rsp_last_in  = (hits_ff[MW-1:1] == '0);
               end
               hits_in    = hits_ff >> 1;
               scan_id_in = scan_id_ff + IW'(1);
               if (hits_ff[MW-1:1] == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      pend0_ff   <= pend0_in;
      pend1_ff   <= pend1_in;
      pend2_ff   <= pend2_in;
      hits_ff    <= hits_in;
      scan_id_ff <= scan_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 2'd0;
         active_ff    <= '0;
         regmask_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         regmask_ff   <= regmask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire
